/* sv/fdf_pkg.sv */
// Shared types, widths and constants of the fall detector.
`default_nettype none

package fdf_pkg;

    // Sample and time precision used inside the block.
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;

    // Field widths on the ports.
    localparam int TIME_W    = 32;
    localparam int ACCEL_W   = 16;
    localparam int LEVEL_W   = 15;
    localparam int MS_W      = 16;
    localparam int STATE_W   = 2;
    localparam int MAGOUT_W  = 32;

    // Squared magnitude: three squares of SAMPLE_BITS values fit in 2*SAMPLE_BITS bits.
    localparam int MAG_W = 2 * SAMPLE_BITS;
    // Width at which magnitude and squared thresholds are compared.
    localparam int CMP_W = (MAG_W > 2 * LEVEL_W) ? MAG_W : 2 * LEVEL_W;

    // Input tdata layout, lowest bit first.
    localparam int IN_TIME_LSB = 0;
    localparam int IN_X_LSB    = IN_TIME_LSB + TIME_W;
    localparam int IN_Y_LSB    = IN_X_LSB + ACCEL_W;
    localparam int IN_Z_LSB    = IN_Y_LSB + ACCEL_W;
    localparam int IN_BTN_BIT  = IN_Z_LSB + ACCEL_W;
    localparam int IN_USED_W   = IN_BTN_BIT + 1;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_STATE_LSB = 0;
    localparam int OUT_ALARM_BIT = OUT_STATE_LSB + STATE_W;
    localparam int OUT_MAG_LSB   = OUT_ALARM_BIT + 1;
    localparam int OUT_USED_W    = OUT_MAG_LSB + MAGOUT_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 3'd4;

    localparam logic [LEVEL_W-1:0] RST_IMPACT_LEVEL = 15'd11469;
    localparam logic [LEVEL_W-1:0] RST_STILL_LEVEL  = 15'd5325;
    localparam logic [MS_W-1:0]    RST_SETTLE_MS    = 16'd1000;
    localparam logic [MS_W-1:0]    RST_STILL_MS     = 16'd1500;
    localparam logic [MS_W-1:0]    RST_DEBOUNCE_MS  = 16'd50;

    // Reported state codes.
    localparam logic [STATE_W-1:0] STATE_NORMAL    = 2'd0;
    localparam logic [STATE_W-1:0] STATE_IMPACT    = 2'd1;
    localparam logic [STATE_W-1:0] STATE_CHECK     = 2'd2;
    localparam logic [STATE_W-1:0] STATE_CONFIRMED = 2'd3;

    // Queue between the classifier and the state machine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [TIME_BITS-1:0] time_ms;
        logic                 button;
        logic                 hard;
        logic                 still;
        logic [MAG_W-1:0]     mag;
    } t_cls_item;

    localparam int CLS_W = $bits(t_cls_item);

endpackage

`default_nettype wire

/* sv/fall_detect_fsm.sv */
// Top level of the accelerometer fall detector with its configuration registers.
//
// Usage: one accelerometer sample enters per item on the slave stream
// (s_axis): a millisecond timestamp, three signed axes and the clear
// button level. Every item yields exactly one result item on the master
// stream (m_axis): the state after that sample, the alarm flag and the
// squared magnitude of the sample.
// Throughput is one item per clock cycle while the receiver is ready. On
// the way to o_m_axis_tvalid, the accepting edge captures the sample in
// stage A, stage B registers the three squaring multipliers, the magnitude
// sum and threshold compares are written into a four-entry queue, and the
// state machine then updates and loads the output register.
// When the receiver stalls, the result stays in the output register, the
// queue absorbs up to four more classified items, and o_s_axis_tready
// falls only once the queue and both front stages are full.
// Synchronous active-low reset empties all stages, returns the machine to
// normal with the button seen as released, and loads the default
// thresholds and times. Configuration writes reach the registers at the
// next clock edge, and the squared thresholds are registered from them; they
// are meant to be made while no item is in flight.
`default_nettype none

module fall_detect_fsm (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Slave tdata, from bit 0: time_ms[31:0], accel_x[15:0], accel_y[15:0],
    // accel_z[15:0], button_level, zero padding to 88 bits.
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [fdf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // Master tdata, from bit 0: fall_state[1:0], fall_alarm,
    // magnitude_sq[31:0], zero padding to 40 bits.
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [fdf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire  [fdf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [fdf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [fdf_pkg::LEVEL_W-1:0]  r_impact_level;
    logic [fdf_pkg::LEVEL_W-1:0]  r_still_level;
    logic [fdf_pkg::MS_W-1:0]     r_settle_ms;
    logic [fdf_pkg::MS_W-1:0]     r_still_ms;
    logic [fdf_pkg::MS_W-1:0]     r_debounce_ms;

    logic                         w_push;
    logic                         w_pop;
    logic                         w_full;
    logic                         w_empty;
    fdf_pkg::t_cls_item           w_wr_item;
    fdf_pkg::t_cls_item           w_rd_item;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_impact_level <= fdf_pkg::RST_IMPACT_LEVEL;
            r_still_level  <= fdf_pkg::RST_STILL_LEVEL;
            r_settle_ms    <= fdf_pkg::RST_SETTLE_MS;
            r_still_ms     <= fdf_pkg::RST_STILL_MS;
            r_debounce_ms  <= fdf_pkg::RST_DEBOUNCE_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fdf_pkg::CFG_IMPACT_LEVEL: r_impact_level <= i_cfg_data[fdf_pkg::LEVEL_W-1:0];
                fdf_pkg::CFG_STILL_LEVEL:  r_still_level  <= i_cfg_data[fdf_pkg::LEVEL_W-1:0];
                fdf_pkg::CFG_SETTLE_MS:    r_settle_ms    <= i_cfg_data[fdf_pkg::MS_W-1:0];
                fdf_pkg::CFG_STILL_MS:     r_still_ms     <= i_cfg_data[fdf_pkg::MS_W-1:0];
                fdf_pkg::CFG_DEBOUNCE_MS:  r_debounce_ms  <= i_cfg_data[fdf_pkg::MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: capture, square and classify each sample.
    fdf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_impact_level  (r_impact_level),
        .i_still_level   (r_still_level),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_item          (w_wr_item)
    );

    // Queue lets the classifier run ahead while the output is stalled.
    fdf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_item (w_wr_item),
        .i_pop     (w_pop),
        .o_rd_item (w_rd_item),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    // Back end: state machine and result register.
    fdf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_rd_item),
        .i_item_valid    (!w_empty),
        .o_pop           (w_pop),
        .i_settle_ms     (r_settle_ms),
        .i_still_ms      (r_still_ms),
        .i_debounce_ms   (r_debounce_ms),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

/* sv/fdf_front.sv */
// Input stage and classifier: squares, magnitude sum and threshold compares.
`default_nettype none

module fdf_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [fdf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  wire  [fdf_pkg::LEVEL_W-1:0]        i_impact_level,
    input  wire  [fdf_pkg::LEVEL_W-1:0]        i_still_level,
    input  wire                                i_q_full,
    output logic                               o_push,
    output fdf_pkg::t_cls_item                 o_item
);

    // Stage A: captured sample.
    logic                                  r_a_valid;
    logic [fdf_pkg::TIME_BITS-1:0]         r_a_time;
    logic signed [fdf_pkg::SAMPLE_BITS-1:0] r_a_x;
    logic signed [fdf_pkg::SAMPLE_BITS-1:0] r_a_y;
    logic signed [fdf_pkg::SAMPLE_BITS-1:0] r_a_z;
    logic                                  r_a_btn;

    // Stage B: squared axes.
    logic                                  r_b_valid;
    logic [fdf_pkg::TIME_BITS-1:0]         r_b_time;
    logic                                  r_b_btn;
    logic [fdf_pkg::MAG_W-1:0]             r_b_sqx;
    logic [fdf_pkg::MAG_W-1:0]             r_b_sqy;
    logic [fdf_pkg::MAG_W-1:0]             r_b_sqz;

    // Squared thresholds, refreshed every cycle from the level registers.
    logic [fdf_pkg::CMP_W-1:0]             r_impact_sq;
    logic [fdf_pkg::CMP_W-1:0]             r_still_sq;

    logic signed [fdf_pkg::MAG_W-1:0]      w_px;
    logic signed [fdf_pkg::MAG_W-1:0]      w_py;
    logic signed [fdf_pkg::MAG_W-1:0]      w_pz;
    logic [fdf_pkg::MAG_W-1:0]             w_mag;
    logic [fdf_pkg::CMP_W-1:0]             w_mag_cmp;
    logic [fdf_pkg::CMP_W-1:0]             w_impact_ext;
    logic [fdf_pkg::CMP_W-1:0]             w_still_ext;
    logic                                  w_b_adv;
    logic                                  w_a_adv;

    assign w_b_adv         = !r_b_valid || !i_q_full;
    assign w_a_adv         = !r_a_valid || w_b_adv;
    assign o_s_axis_tready = w_a_adv;
    assign o_push          = r_b_valid && !i_q_full;

    assign w_px = r_a_x * r_a_x;
    assign w_py = r_a_y * r_a_y;
    assign w_pz = r_a_z * r_a_z;

    assign w_mag     = r_b_sqx + r_b_sqy + r_b_sqz;
    assign w_mag_cmp = fdf_pkg::CMP_W'(w_mag);

    // Levels are widened first so the square keeps all of its bits.
    assign w_impact_ext = fdf_pkg::CMP_W'(i_impact_level);
    assign w_still_ext  = fdf_pkg::CMP_W'(i_still_level);

    always_comb begin
        o_item.time_ms = r_b_time;
        o_item.button  = r_b_btn;
        o_item.hard    = w_mag_cmp > r_impact_sq;
        o_item.still   = w_mag_cmp < r_still_sq;
        o_item.mag     = w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_adv) begin
                r_a_valid <= i_s_axis_tvalid;
            end
            if (w_b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_impact_sq <= w_impact_ext * w_impact_ext;
        r_still_sq  <= w_still_ext * w_still_ext;
        if (w_a_adv && i_s_axis_tvalid) begin
            r_a_time <= i_s_axis_tdata[fdf_pkg::IN_TIME_LSB +: fdf_pkg::TIME_BITS];
            r_a_x    <= i_s_axis_tdata[fdf_pkg::IN_X_LSB +: fdf_pkg::SAMPLE_BITS];
            r_a_y    <= i_s_axis_tdata[fdf_pkg::IN_Y_LSB +: fdf_pkg::SAMPLE_BITS];
            r_a_z    <= i_s_axis_tdata[fdf_pkg::IN_Z_LSB +: fdf_pkg::SAMPLE_BITS];
            r_a_btn  <= i_s_axis_tdata[fdf_pkg::IN_BTN_BIT];
        end
        if (w_b_adv && r_a_valid) begin
            r_b_time <= r_a_time;
            r_b_btn  <= r_a_btn;
            r_b_sqx  <= $unsigned(w_px);
            r_b_sqy  <= $unsigned(w_py);
            r_b_sqz  <= $unsigned(w_pz);
        end
    end

endmodule

`default_nettype wire

/* sv/fdf_queue.sv */
// Short register queue between the classifier and the state machine.
`default_nettype none

module fdf_queue (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire fdf_pkg::t_cls_item     i_wr_item,
    input  wire                         i_pop,
    output fdf_pkg::t_cls_item          o_rd_item,
    output logic                        o_full,
    output logic                        o_empty
);

    fdf_pkg::t_cls_item                r_mem [fdf_pkg::QUEUE_DEPTH];
    logic [fdf_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [fdf_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [fdf_pkg::QCNT_W-1:0]        r_count;

    assign o_full    = (r_count == fdf_pkg::QCNT_W'(fdf_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    // The classifier must hold its item while the queue is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    // The state machine must only take an item that is present.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fdf_pkg::QCNT_W'(fdf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* sv/fdf_back.sv */
// Fall state machine, button debounce and registered result output.
`default_nettype none

module fdf_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire fdf_pkg::t_cls_item            i_item,
    input  wire                                i_item_valid,
    output logic                               o_pop,
    input  wire  [fdf_pkg::MS_W-1:0]           i_settle_ms,
    input  wire  [fdf_pkg::MS_W-1:0]           i_still_ms,
    input  wire  [fdf_pkg::MS_W-1:0]           i_debounce_ms,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [fdf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    typedef enum logic [3:0] {
        PH_NORMAL    = 4'b0001,
        PH_IMPACT    = 4'b0010,
        PH_CHECK     = 4'b0100,
        PH_CONFIRMED = 4'b1000
    } t_phase;

    t_phase                            r_phase,       n_phase;
    logic [fdf_pkg::TIME_BITS-1:0]     r_phase_time,  n_phase_time;
    logic                              r_btn_prev,    n_btn_prev;
    logic                              r_btn_stable,  n_btn_stable;
    logic [fdf_pkg::TIME_BITS-1:0]     r_bounce_time, n_bounce_time;
    logic                              r_out_valid;
    logic [fdf_pkg::OUT_DATA_W-1:0]    r_out_data,    n_out_data;

    logic [fdf_pkg::TIME_BITS-1:0]     w_now;
    logic [fdf_pkg::TIME_BITS-1:0]     w_el_phase;
    logic [fdf_pkg::TIME_BITS-1:0]     w_el_bounce;
    logic [fdf_pkg::STATE_W-1:0]       w_state_code;

    assign o_pop           = i_item_valid && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_now      = i_item.time_ms;
    assign w_el_phase = w_now - r_phase_time;
    // A level change restarts the debounce window at this item's time.
    assign w_el_bounce = (i_item.button != r_btn_prev) ? '0 : (w_now - r_bounce_time);

    always_comb begin
        n_phase       = r_phase;
        n_phase_time  = r_phase_time;
        n_btn_prev    = r_btn_prev;
        n_btn_stable  = r_btn_stable;
        n_bounce_time = r_bounce_time;
        case (r_phase)
            PH_NORMAL: begin
                if (i_item.hard) begin
                    n_phase      = PH_IMPACT;
                    n_phase_time = w_now;
                end
            end
            PH_IMPACT: begin
                if (w_el_phase > fdf_pkg::TIME_BITS'(i_settle_ms)) begin
                    if (i_item.still) begin
                        n_phase      = PH_CHECK;
                        n_phase_time = w_now;
                    end else begin
                        n_phase = PH_NORMAL;
                    end
                end
            end
            PH_CHECK: begin
                if (i_item.still) begin
                    if (w_el_phase > fdf_pkg::TIME_BITS'(i_still_ms)) begin
                        n_phase      = PH_CONFIRMED;
                        n_phase_time = w_now;
                    end
                end else begin
                    n_phase = PH_NORMAL;
                end
            end
            PH_CONFIRMED: begin
                if (i_item.button != r_btn_prev) begin
                    n_bounce_time = w_now;
                end
                if (w_el_bounce > fdf_pkg::TIME_BITS'(i_debounce_ms)) begin
                    // A settled press clears the fall.
                    if (!i_item.button && r_btn_stable) begin
                        n_phase = PH_NORMAL;
                    end
                    n_btn_stable = i_item.button;
                end
                n_btn_prev = i_item.button;
            end
            default: begin
                n_phase = PH_NORMAL;
            end
        endcase
    end

    always_comb begin
        case (n_phase)
            PH_NORMAL:    w_state_code = fdf_pkg::STATE_NORMAL;
            PH_IMPACT:    w_state_code = fdf_pkg::STATE_IMPACT;
            PH_CHECK:     w_state_code = fdf_pkg::STATE_CHECK;
            PH_CONFIRMED: w_state_code = fdf_pkg::STATE_CONFIRMED;
            default:      w_state_code = fdf_pkg::STATE_NORMAL;
        endcase
        n_out_data = '0;
        n_out_data[fdf_pkg::OUT_STATE_LSB +: fdf_pkg::STATE_W] = w_state_code;
        n_out_data[fdf_pkg::OUT_ALARM_BIT] = (n_phase == PH_CONFIRMED);
        n_out_data[fdf_pkg::OUT_MAG_LSB +: fdf_pkg::MAGOUT_W] =
            fdf_pkg::MAGOUT_W'(i_item.mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NORMAL;
            r_phase_time  <= '0;
            r_btn_prev    <= 1'b1;
            r_btn_stable  <= 1'b1;
            r_bounce_time <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase       <= n_phase;
                r_phase_time  <= n_phase_time;
                r_btn_prev    <= n_btn_prev;
                r_btn_stable  <= n_btn_stable;
                r_bounce_time <= n_bounce_time;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    // No item is processed while the held result waits.
    a_hold_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_phase))
        else $error("phase advanced while result stalled");

    // From normal the only way out is through impact.
    a_normal_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NORMAL) |=> (r_phase == PH_NORMAL || r_phase == PH_IMPACT))
        else $error("normal left other than to impact");

endmodule

`default_nettype wire

/* sim/fall_detect_fsm_test.sv */
// Self-checking bench for the fall detector: stream driver, result monitor and predictor.
`default_nettype none

module fall_detect_fsm_test;
    import fdf_pkg::*;

    // Indexes above the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_DEBOUNCE_MS + 1'b1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [TIME_W-1:0]         stamp;
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        logic                      btn;
    } sample_t;

    typedef struct {
        logic [STATE_W-1:0]  state;
        logic                alarm;
        logic [MAGOUT_W-1:0] mag;
    } verdict_t;

    // Kinds of acceleration vector the stimulus asks for.
    typedef enum int {V_QUIET, V_HARD, V_ROAM} shape_t;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire [OUT_DATA_W-1:0]  m_data;

    fall_detect_fsm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Thresholds and times as the block should hold them.
    logic [LEVEL_W-1:0] cfg_impact   = RST_IMPACT_LEVEL;
    logic [LEVEL_W-1:0] cfg_still    = RST_STILL_LEVEL;
    logic [MS_W-1:0]    cfg_settle   = RST_SETTLE_MS;
    logic [MS_W-1:0]    cfg_still_ms = RST_STILL_MS;
    logic [MS_W-1:0]    cfg_debounce = RST_DEBOUNCE_MS;

    // Detector state as the block should hold it.
    logic [STATE_W-1:0] fsm_phase    = STATE_NORMAL;
    logic [TIME_W-1:0]  phase_stamp  = '0;
    logic               btn_last     = 1'b1;
    logic               btn_settled  = 1'b1;
    logic [TIME_W-1:0]  bounce_stamp = '0;

    sample_t  samples_waiting[$];
    verdict_t outcomes_due[$];
    sample_t  on_wire;

    logic [TIME_W-1:0] clock_ms = '0;
    bit sender_idles = 1'b1;
    bit sink_idles   = 1'b1;
    bit calm_tail    = 1'b0;
    int send_gap     = 0;
    int sink_stall   = 0;
    int built        = 0;

    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int settings_used   = 0;
    int falls_confirmed = 0;
    int falls_cleared   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Timed out with %0d results still expected.", outcomes_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned energy(logic signed [ACCEL_W-1:0] x,
                                               logic signed [ACCEL_W-1:0] y,
                                               logic signed [ACCEL_W-1:0] z);
        longint a, b, c;
        a = x;
        b = y;
        c = z;
        return a * a + b * b + c * c;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_sample(sample_t s);
        logic [IN_DATA_W-1:0] w;
        w = '0;
        w[IN_TIME_LSB +: TIME_W] = s.stamp;
        w[IN_X_LSB +: ACCEL_W]   = s.ax;
        w[IN_Y_LSB +: ACCEL_W]   = s.ay;
        w[IN_Z_LSB +: ACCEL_W]   = s.az;
        w[IN_BTN_BIT]            = s.btn;
        return w;
    endfunction

    // Steps the expected detector by one accepted sample and queues its result.
    function automatic void advance_detector(sample_t s);
        longint unsigned mag, impact_sq, still_sq;
        logic [TIME_W-1:0] since;
        logic hard, quiet;
        logic [STATE_W-1:0] was;
        verdict_t v;
        mag       = energy(s.ax, s.ay, s.az);
        impact_sq = cfg_impact;
        impact_sq = impact_sq * impact_sq;
        still_sq  = cfg_still;
        still_sq  = still_sq * still_sq;
        hard  = mag > impact_sq;
        quiet = mag < still_sq;
        was   = fsm_phase;
        case (fsm_phase)
            STATE_NORMAL: begin
                if (hard) begin
                    fsm_phase   = STATE_IMPACT;
                    phase_stamp = s.stamp;
                end
            end
            STATE_IMPACT: begin
                since = s.stamp - phase_stamp;
                if (since > cfg_settle) begin
                    if (quiet) begin
                        fsm_phase   = STATE_CHECK;
                        phase_stamp = s.stamp;
                    end else begin
                        fsm_phase = STATE_NORMAL;
                    end
                end
            end
            STATE_CHECK: begin
                since = s.stamp - phase_stamp;
                if (!quiet) begin
                    fsm_phase = STATE_NORMAL;
                end else if (since > cfg_still_ms) begin
                    fsm_phase   = STATE_CONFIRMED;
                    phase_stamp = s.stamp;
                end
            end
            default: begin
                // The button is only followed while a fall is confirmed.
                if (s.btn != btn_last) begin
                    bounce_stamp = s.stamp;
                end
                since = s.stamp - bounce_stamp;
                if (since > cfg_debounce) begin
                    if (!s.btn && btn_settled) begin
                        fsm_phase = STATE_NORMAL;
                    end
                    btn_settled = s.btn;
                end
                btn_last = s.btn;
            end
        endcase
        if (fsm_phase == STATE_CONFIRMED && was != STATE_CONFIRMED) begin
            falls_confirmed++;
        end
        if (fsm_phase == STATE_NORMAL && was == STATE_CONFIRMED) begin
            falls_cleared++;
        end
        v.state = fsm_phase;
        v.alarm = (fsm_phase == STATE_CONFIRMED);
        v.mag   = mag[MAGOUT_W-1:0];
        outcomes_due.push_back(v);
    endfunction

    function automatic void note_miss(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("Mismatch: %s", msg);
        end
    endfunction

    function automatic void check_result(logic [OUT_DATA_W-1:0] d);
        verdict_t want, got;
        got.state = d[OUT_STATE_LSB +: STATE_W];
        got.alarm = d[OUT_ALARM_BIT];
        got.mag   = d[OUT_MAG_LSB +: MAGOUT_W];
        results_checked++;
        if (outcomes_due.size() == 0) begin
            note_miss($sformatf("result %0d arrived with nothing expected, data %h",
                                results_checked, d));
            return;
        end
        want = outcomes_due.pop_front();
        if (got.state != want.state) begin
            note_miss($sformatf("result %0d state expected %0d got %0d",
                                results_checked, want.state, got.state));
        end
        if (got.alarm != want.alarm) begin
            note_miss($sformatf("result %0d alarm expected %0d got %0d",
                                results_checked, want.alarm, got.alarm));
        end
        if (got.mag != want.mag) begin
            note_miss($sformatf("result %0d magnitude expected %0d got %0d",
                                results_checked, want.mag, got.mag));
        end
    endfunction

    // Sender: offers queued samples, with random bursts of idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                advance_detector(on_wire);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (samples_waiting.size() > 0) begin
                    on_wire = samples_waiting.pop_front();
                    s_data  <= pack_sample(on_wire);
                    s_valid <= 1'b1;
                    if (sender_idles && !calm_tail && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 9);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result and stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (sink_idles && !calm_tail && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_IMPACT_LEVEL: cfg_impact   = val[LEVEL_W-1:0];
            CFG_STILL_LEVEL:  cfg_still    = val[LEVEL_W-1:0];
            CFG_SETTLE_MS:    cfg_settle   = val[MS_W-1:0];
            CFG_STILL_MS:     cfg_still_ms = val[MS_W-1:0];
            CFG_DEBOUNCE_MS:  cfg_debounce = val[MS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued sample went in and every result came out.
    task automatic drain();
        @(negedge i_clk);
        while (samples_waiting.size() != 0 || s_valid || outcomes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Builds a vector of the asked kind against the current thresholds.
    function automatic sample_t shaped(shape_t k, logic btn);
        sample_t s;
        int lim, i;
        longint unsigned floor_sq;
        bit ok;
        s.stamp = clock_ms;
        s.btn   = btn;
        case (k)
            V_QUIET: begin
                // Each axis at most half the level keeps the sum below a nonzero squared level.
                lim  = cfg_still / 2;
                s.ax = ACCEL_W'(int'($urandom_range(0, 2 * lim)) - lim);
                s.ay = ACCEL_W'(int'($urandom_range(0, 2 * lim)) - lim);
                s.az = ACCEL_W'(int'($urandom_range(0, 2 * lim)) - lim);
            end
            V_HARD: begin
                floor_sq = cfg_impact;
                floor_sq = floor_sq * floor_sq;
                ok = 1'b0;
                for (i = 0; i < 8 && !ok; i++) begin
                    s.ax = ACCEL_W'($urandom);
                    s.ay = ACCEL_W'($urandom);
                    s.az = ACCEL_W'($urandom);
                    ok = energy(s.ax, s.ay, s.az) > floor_sq;
                end
                if (!ok) begin
                    // Full negative scale on all axes beats any threshold.
                    s.ax = {1'b1, {(ACCEL_W-1){1'b0}}};
                    s.ay = s.ax;
                    s.az = s.ax;
                end
            end
            default: begin
                s.ax = ACCEL_W'($urandom);
                s.ay = ACCEL_W'($urandom);
                s.az = ACCEL_W'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic push_step(int unsigned d, shape_t k, logic btn);
        clock_ms += d;
        samples_waiting.push_back(shaped(k, btn));
        built++;
    endtask

    task automatic put_at(logic [TIME_W-1:0] stamp, int x, int y, int z, logic btn);
        sample_t s;
        s.stamp = stamp;
        s.ax    = x[ACCEL_W-1:0];
        s.ay    = y[ACCEL_W-1:0];
        s.az    = z[ACCEL_W-1:0];
        s.btn   = btn;
        samples_waiting.push_back(s);
        clock_ms = stamp;
    endtask

    function automatic logic coin();
        return logic'($urandom_range(0, 1));
    endfunction

    // A fall with random content: impact, settle, stillness, confirm, button clear.
    // Now and then the sequence breaks off with movement or stays confirmed.
    task automatic queue_fall();
        int unsigned span, d, n, i;
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
            push_step($urandom_range(1, 40), V_QUIET, coin());
        end
        push_step($urandom_range(1, 40), V_HARD, coin());

        span = 0;
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
            d = $urandom_range(0, cfg_settle / 4);
            span += d;
            push_step(d, coin() ? V_ROAM : V_QUIET, coin());
        end
        if ($urandom_range(0, 3) == 0) begin
            // Exactly the settle time has not yet passed.
            push_step(cfg_settle - span, V_QUIET, coin());
            span = cfg_settle;
        end
        if ($urandom_range(0, 7) == 0) begin
            push_step(cfg_settle - span + $urandom_range(1, 20), V_ROAM, coin());
            return;
        end
        push_step(cfg_settle - span + $urandom_range(1, 20), V_QUIET, coin());

        span = 0;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            d = $urandom_range(0, cfg_still_ms / 4);
            span += d;
            if ($urandom_range(0, 11) == 0) begin
                push_step(d, V_ROAM, coin());
                return;
            end
            push_step(d, V_QUIET, coin());
        end
        if ($urandom_range(0, 3) == 0) begin
            push_step(cfg_still_ms - span, V_QUIET, coin());
            span = cfg_still_ms;
        end
        push_step(cfg_still_ms - span + $urandom_range(1, 20), V_QUIET, coin());

        // Button bounce, then a clean release and a held press.
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            push_step($urandom_range(0, cfg_debounce / 2), V_ROAM, coin());
        end
        if ($urandom_range(0, 5) == 0) begin
            return;
        end
        push_step($urandom_range(1, 10), V_ROAM, 1'b1);
        push_step(cfg_debounce + $urandom_range(1, 10), V_ROAM, 1'b1);
        push_step($urandom_range(1, 10), V_ROAM, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            push_step(cfg_debounce, V_ROAM, 1'b0);
        end
        push_step(cfg_debounce + $urandom_range(1, 10), V_ROAM, 1'b0);
    endtask

    // Random samples with random time jumps, wrapping jumps included.
    task automatic queue_noise();
        int unsigned n, i, d;
        n = $urandom_range(2, 6);
        for (i = 0; i < n; i++) begin
            d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
            push_step(d, shape_t'($urandom_range(0, 2)), coin());
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] imp, logic [CFG_DATA_W-1:0] still,
                             logic [CFG_DATA_W-1:0] settle, logic [CFG_DATA_W-1:0] hold,
                             logic [CFG_DATA_W-1:0] deb, int quota);
        write_reg(CFG_IMPACT_LEVEL, imp);
        write_reg(CFG_STILL_LEVEL, still);
        write_reg(CFG_SETTLE_MS, settle);
        write_reg(CFG_STILL_MS, hold);
        write_reg(CFG_DEBOUNCE_MS, deb);
        write_reg(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        sender_idles = ($urandom_range(0, 4) != 0);
        sink_idles   = ($urandom_range(0, 4) != 0);
        @(negedge i_clk);
        built = 0;
        while (built < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_fall();
            end else begin
                queue_noise();
            end
        end
        settings_used++;
        drain();
    endtask

    // Default thresholds: magnitude boundaries, full-scale axes, a wrapped
    // timestamp inside the settle window, and a bouncing button clear.
    task automatic queue_directed();
        int unsigned c;
        put_at(32'd0, 0, 0, 0, 1'b0);
        put_at(32'd5, RST_IMPACT_LEVEL, 0, 0, 1'b1);
        put_at(32'd6, 32767, 32767, 32767, 1'b0);
        put_at(32'd1006, 0, 0, 0, 1'b1);
        put_at(32'd1007, RST_STILL_LEVEL, 0, 0, 1'b1);
        put_at(32'hFFFF_FF00, -(RST_IMPACT_LEVEL + 1), 0, 0, 1'b1);
        put_at(32'hFFFF_FFFF, -1, -1, -1, 1'b0);
        put_at(32'h0000_02F0, 1, 0, -1, 1'b1);
        put_at(32'h0000_02F0 + RST_STILL_MS, 100, -100, 0, 1'b1);
        c = 32'h0000_02F0 + RST_STILL_MS + 1;
        put_at(c, 0, 0, -1, 1'b1);
        put_at(c + 10, -32768, -32768, -32768, 1'b1);
        put_at(c + 20, 0, 0, 0, 1'b0);
        put_at(c + 30, 0, 0, 0, 1'b1);
        put_at(c + 40, 0, 0, 0, 1'b0);
        put_at(c + 40 + RST_DEBOUNCE_MS, 0, 0, 0, 1'b0);
        put_at(c + 41 + RST_DEBOUNCE_MS, 0, 0, 0, 1'b0);
        c = c + 100;
        put_at(c, 32767, -32768, 32767, 1'b1);
        put_at(c, 0, 0, 0, 1'b1);
        put_at(c + RST_SETTLE_MS + 1, 8000, 0, 0, 1'b0);
        c = c + 1200;
        put_at(c, 21845, -21846, 0, 1'b1);
        put_at(c + RST_SETTLE_MS + 1, 0, 0, 0, 1'b0);
        put_at(c + RST_SETTLE_MS + 3, 12000, 0, 0, 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        settings_used++;
        drain();

        clock_ms = $urandom;
        run_phase(16'd9000, 16'd5000, 16'd20, 16'd30, 16'd5, 65);
        run_phase(16'd0, 16'd32767, 16'd0, 16'd0, 16'd0, 65);
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        run_phase(16'd32767, 16'd32767, 16'd65535, 16'd65535, 16'd65535, 65);
        run_phase(16'd16000, 16'd0, 16'd300, 16'd700, 16'd40, 50);
        // Raw 16-bit level writes check that the top bit is dropped.
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(0, 2000)), CFG_DATA_W'($urandom_range(0, 2000)),
                  CFG_DATA_W'($urandom_range(0, 200)), 65);
        calm_tail = 1'b1;
        run_phase(RST_IMPACT_LEVEL, RST_STILL_LEVEL, RST_SETTLE_MS, RST_STILL_MS,
                  RST_DEBOUNCE_MS, 65);

        repeat (8) @(negedge i_clk);
        $display("Run covered %0d samples under %0d threshold settings, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Falls confirmed %0d times and cleared %0d times; %0d mismatches.",
                 falls_confirmed, falls_cleared, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/fdf_pkg.sv
sv/fdf_front.sv
sv/fdf_queue.sv
sv/fdf_back.sv
sv/fall_detect_fsm.sv
sim/fall_detect_fsm_test.sv
